### sv/wet_pkg.sv
// ----------------------------------------------------------------------------
// wet_pkg
// Types and constants shared by the weighted edge table modules.
// ----------------------------------------------------------------------------
package wet_pkg;

  localparam int CapDefault = 32;
  localparam int KeyW = 31;
  localparam int WgtW = 32;
  localparam int StepW = 31;
  localparam int CntW = 6;

  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_DELETE = 3'd1;
  localparam logic [2:0] REQ_SETW   = 3'd2;
  localparam logic [2:0] REQ_LOOKUP = 3'd3;
  localparam logic [2:0] REQ_RECENT = 3'd4;
  localparam logic [2:0] REQ_MAXW   = 3'd5;
  localparam logic [2:0] REQ_MINW   = 3'd6;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [WgtW-1:0] WEIGHT_ONE = 32'h0001_0000;

  typedef struct packed {
    logic [2:0]       req_type;
    logic             direction;
    logic [KeyW-1:0]  neighbor_key;
    logic [WgtW-1:0]  new_weight;
    logic [StepW-1:0] current_step;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KeyW-1:0]  result_key;
    logic [WgtW-1:0]  result_weight;
    logic [StepW-1:0] result_step;
    logic [CntW-1:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [WgtW-1:0]  wgt;
    logic [StepW-1:0] step;
  } entry_t;

  typedef enum logic [2:0] {
    CMP_EQ  = 3'b001,
    CMP_GTS = 3'b010,
    CMP_LTS = 3'b100
  } cmp_op_t;

endpackage

### sv/wet_cmp.sv
// ----------------------------------------------------------------------------
// wet_cmp
// Shared compare unit: key match, unsigned step compare, signed weight compare.
// ----------------------------------------------------------------------------
module wet_cmp (
  input  wet_pkg::cmp_op_t       op,
  input  logic                   is_step,
  input  wet_pkg::entry_t        cand,
  input  wet_pkg::entry_t        best,
  input  logic [wet_pkg::KeyW-1:0] key,
  output logic                   hit
);
  always_comb begin
    unique case (op)
      wet_pkg::CMP_EQ:  hit = (cand.key == key);
      wet_pkg::CMP_GTS: hit = is_step ? (cand.step > best.step)
                                      : ($signed(cand.wgt) > $signed(best.wgt));
      wet_pkg::CMP_LTS: hit = ($signed(cand.wgt) < $signed(best.wgt));
      default:          hit = 1'b0;
    endcase
  end
endmodule

### sv/weighted_edge_table_core.sv
// ----------------------------------------------------------------------------
// weighted_edge_table_core
// Two associative edge tables (outward, inward) with scan-based requests.
// ----------------------------------------------------------------------------
// One request at a time. A request scans the filled part of its table one
// entry per cycle through a single compare unit reading a registered-output
// memory (non-query requests stop at a key match), then passes through S_RDL,
// S_WR and S_RDSEL: reading the last or selected entry, writing back and
// re-reading the selected entry. in_stall is high from accept until the
// result is transferred; a result waits in an output register.
module weighted_edge_table_core #(
  parameter int CAP = wet_pkg::CapDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wet_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wet_pkg::out_item_t out_data
);
  localparam int IW = $clog2(CAP) + 1;
  localparam int AW = IW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_RDL   = 6'b000100,
    S_WR    = 6'b001000,
    S_RDSEL = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  wet_pkg::in_item_t req_r;
  logic [IW-1:0] fill_r [2];
  logic [IW-1:0] idx_r, sel_r, fill_c;
  logic          found_r, rd_vld_r, first_r, full_r;
  logic [IW-1:0] rd_idx_r;
  wet_pkg::entry_t mem [2*CAP];
  wet_pkg::entry_t rd_q, best_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  wet_pkg::entry_t wr_d;
  wet_pkg::out_item_t res_r, res_nxt;
  logic          hit;
  wet_pkg::cmp_op_t op;
  logic          is_query;

  assign fill_c = fill_r[req_r.direction];
  assign is_query = (req_r.req_type == wet_pkg::REQ_RECENT) ||
                    (req_r.req_type == wet_pkg::REQ_MAXW) ||
                    (req_r.req_type == wet_pkg::REQ_MINW);

  always_comb begin
    unique case (req_r.req_type)
      wet_pkg::REQ_RECENT, wet_pkg::REQ_MAXW: op = wet_pkg::CMP_GTS;
      wet_pkg::REQ_MINW:                      op = wet_pkg::CMP_LTS;
      default:                                op = wet_pkg::CMP_EQ;
    endcase
  end

  wet_cmp u_cmp (
    .op      (op),
    .is_step (req_r.req_type == wet_pkg::REQ_RECENT),
    .cand    (rd_q),
    .best    (best_r),
    .key     (req_r.neighbor_key),
    .hit     (hit)
  );

  function automatic logic [AW-1:0] addr_of(input logic d, input logic [IW-1:0] i);
    logic [AW:0] a;
    a = (AW+1)'(d) * (AW+1)'(CAP) + (AW+1)'(i);
    return a[AW-1:0];
  endfunction

  always_comb begin
    rd_addr = addr_of(req_r.direction, idx_r);
    if (state_r == S_RDL)
      rd_addr = addr_of(req_r.direction, (req_r.req_type == wet_pkg::REQ_DELETE) ?
                                         fill_c - IW'(1) : sel_r);
    if (state_r == S_RDSEL || state_r == S_OUT) rd_addr = addr_of(req_r.direction, sel_r);
    wr_en = 1'b0;
    wr_addr = addr_of(req_r.direction, sel_r);
    wr_d = rd_q;
    if (state_r == S_WR) begin
      unique case (req_r.req_type)
        wet_pkg::REQ_ADD: begin
          wr_en = !found_r && (fill_c < IW'(CAP));
          wr_addr = addr_of(req_r.direction, fill_c);
          wr_d = '{key: req_r.neighbor_key, wgt: wet_pkg::WEIGHT_ONE,
                   step: req_r.current_step};
        end
        wet_pkg::REQ_DELETE: wr_en = found_r;
        wet_pkg::REQ_SETW: begin
          wr_en = found_r;
          wr_d = '{key: rd_q.key, wgt: req_r.new_weight, step: rd_q.step};
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_d;
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  if ((idx_r >= fill_c || (found_r && !is_query)) && !rd_vld_r)
                 state_nxt = S_RDL;
      S_RDL:   state_nxt = S_WR;
      S_WR:    state_nxt = S_RDSEL;
      S_RDSEL: state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r[0] <= '0;
      fill_r[1] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_WR) begin
        if (req_r.req_type == wet_pkg::REQ_ADD && !found_r && fill_c < IW'(CAP))
          fill_r[req_r.direction] <= fill_c + IW'(1);
        if (req_r.req_type == wet_pkg::REQ_DELETE && found_r)
          fill_r[req_r.direction] <= fill_c - IW'(1);
      end
    end
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.status = wet_pkg::ST_OK;
    res_nxt.entry_count = wet_pkg::CntW'(fill_c);
    unique case (req_r.req_type)
      wet_pkg::REQ_ADD:
        if (!found_r && full_r) res_nxt.status = wet_pkg::ST_FULL;
      wet_pkg::REQ_DELETE, wet_pkg::REQ_SETW, wet_pkg::REQ_LOOKUP,
      wet_pkg::REQ_RECENT, wet_pkg::REQ_MAXW, wet_pkg::REQ_MINW:
        if (!found_r) res_nxt.status = wet_pkg::ST_ABSENT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        req_r <= in_data;
        idx_r <= '0;
        sel_r <= '0;
        found_r <= 1'b0;
        rd_vld_r <= 1'b0;
        first_r <= 1'b1;
      end
      S_SCAN: begin
        rd_vld_r <= (idx_r < fill_c) && !(found_r && !is_query);
        rd_idx_r <= idx_r;
        if (idx_r < fill_c && !(found_r && !is_query)) idx_r <= idx_r + IW'(1);
        if (rd_vld_r && !(found_r && !is_query)) begin
          if (is_query) begin
            if (first_r || hit) begin
              best_r <= rd_q;
              sel_r <= rd_idx_r;
            end
            first_r <= 1'b0;
            found_r <= 1'b1;
          end else if (hit) begin
            found_r <= 1'b1;
            sel_r <= rd_idx_r;
          end
        end
      end
      S_WR: full_r <= (fill_c == IW'(CAP));
      S_RDSEL: res_r <= res_nxt;
      default: ;
    endcase
    if (state_r == S_RDSEL) first_r <= 1'b0;
  end

  // Select fields from the re-read entry in the output stage.
  wet_pkg::out_item_t out_c;
  always_comb begin
    out_c = res_r;
    if (found_r && (is_query || req_r.req_type == wet_pkg::REQ_LOOKUP)) begin
      out_c.result_key = rd_q.key;
      out_c.result_weight = rd_q.wgt;
      out_c.result_step = rd_q.step;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_c;

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= IW'(CAP)) && (fill_r[1] <= IW'(CAP)))
    else $error("fill count beyond capacity");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_WR |=> $stable(fill_r[0]) && $stable(fill_r[1]))
    else $error("fill changed outside write-back");
endmodule
